@@ rtl/core/velocity_motion_model_step_top_defines.svh @@
// Assertion macros used by the checker file of the motion model block.
// Depends on nothing; include by bare file name.
`ifndef VELOCITY_MOTION_MODEL_STEP_TOP_DEFINES_SVH
`define VELOCITY_MOTION_MODEL_STEP_TOP_DEFINES_SVH

// Antecedent in this cycle, consequent in the next, held off during reset.
`define VMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Same-cycle implication, held off during reset.
`define VMM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication that also covers reset itself.
`define VMM_ASSERT_RST(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/vmm_pkg.sv @@
// Shared types, constants and helper functions of the velocity motion model.
// Depends on nothing; used by the top level, the divider and the checker.
`default_nettype none

package vmm_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_COUNT        = 24;

    // 2^31/pi in Q0 and the CORDIC gain 0.6072529 in Q30
    localparam logic [30:0] RAD_TO_BAM  = 31'd683565276;
    localparam logic [33:0] CORDIC_GAIN = 34'd652032874;
    localparam logic signed [32:0] HALF_TURN    = 33'sd2147483648;
    localparam logic signed [32:0] QUARTER_TURN = 33'sd1073741824;

    localparam logic [31:0] ATAN_BAM [ATAN_COUNT] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // divider geometry: numerator, divisor and quotient widths
    localparam int DIV_NW = 68;
    localparam int DIV_DW = 46;
    localparam int DIV_QW = DIV_NW - 14;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] head_angle;
        logic signed [31:0] lin_vel;
        logic signed [31:0] ang_vel;
        logic signed [31:0] turn_vel;
        logic signed [31:0] noise_lin;
        logic signed [31:0] noise_ang;
        logic signed [31:0] noise_turn;
        logic               last_particle;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] next_x;
        logic signed [31:0] next_y;
        logic signed [15:0] next_heading;
        logic               batch_end;
    } t_out_item;

    // payload riding along the CORDIC stages
    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] v;
        logic signed [31:0] w;
        logic signed [32:0] vd;
        logic [15:0]        head;
        logic               last;
    } t_cside;

    // payload riding along the divider stages
    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] nx0;
        logic signed [31:0] ny0;
        logic               wz;
        logic               negx;
        logic               negy;
        logic [15:0]        head;
        logic               last;
    } t_dside;

    // clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [31:0] sat_to32(input logic signed [55:0] a);
        logic signed [31:0] res;
        if (a > 56'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
        end else if (a < -56'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = a[31:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/vmm_div.sv @@
// Pipelined restoring divider: two numerators over one shared divisor, one
// quotient bit per stage. Depends on vmm_pkg.
`default_nettype none

module vmm_div
    import vmm_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire logic                i_valid,
    input  wire logic [DIV_NW-1:0]   i_num_x,
    input  wire logic [DIV_NW-1:0]   i_num_y,
    input  wire logic [DIV_DW-1:0]   i_den,
    input  wire t_dside              i_side,
    output logic                     o_valid,
    output logic [DIV_QW-1:0]        o_quo_x,
    output logic [DIV_QW-1:0]        o_quo_y,
    output t_dside                   o_side
);

    logic                r_valid [DIV_QW+1];
    logic [DIV_DW:0]     r_rem_x [DIV_QW+1];
    logic [DIV_DW:0]     r_rem_y [DIV_QW+1];
    logic [DIV_QW-1:0]   r_low_x [DIV_QW+1];
    logic [DIV_QW-1:0]   r_low_y [DIV_QW+1];
    logic [DIV_QW-1:0]   r_q_x   [DIV_QW+1];
    logic [DIV_QW-1:0]   r_q_y   [DIV_QW+1];
    logic [DIV_DW-1:0]   r_den   [DIV_QW+1];
    t_dside              r_side  [DIV_QW+1];

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= DIV_QW; s++) begin
                r_valid[s] <= 1'b0;
            end
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int s = 0; s < DIV_QW; s++) begin
                r_valid[s+1] <= r_valid[s];
            end
        end
    end

    // load: the top numerator bits are known to stay below the divisor
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem_x[0] <= (DIV_DW+1)'(i_num_x[DIV_NW-1:DIV_QW]);
            r_rem_y[0] <= (DIV_DW+1)'(i_num_y[DIV_NW-1:DIV_QW]);
            r_low_x[0] <= i_num_x[DIV_QW-1:0];
            r_low_y[0] <= i_num_y[DIV_QW-1:0];
            r_q_x[0]   <= '0;
            r_q_y[0]   <= '0;
            r_den[0]   <= i_den;
            r_side[0]  <= i_side;
        end
    end

    // one restoring step per stage
    for (genvar s = 0; s < DIV_QW; s++) begin : g_step
        logic [DIV_DW:0] w_tx, w_ty;
        logic            w_gx, w_gy;

        assign w_tx = {r_rem_x[s][DIV_DW-1:0], r_low_x[s][DIV_QW-1-s]};
        assign w_ty = {r_rem_y[s][DIV_DW-1:0], r_low_y[s][DIV_QW-1-s]};
        assign w_gx = (w_tx >= {1'b0, r_den[s]});
        assign w_gy = (w_ty >= {1'b0, r_den[s]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem_x[s+1] <= w_gx ? (w_tx - {1'b0, r_den[s]}) : w_tx;
                r_rem_y[s+1] <= w_gy ? (w_ty - {1'b0, r_den[s]}) : w_ty;
                r_low_x[s+1] <= r_low_x[s];
                r_low_y[s+1] <= r_low_y[s];
                r_q_x[s+1]   <= r_q_x[s] | (DIV_QW'(w_gx) << (DIV_QW-1-s));
                r_q_y[s+1]   <= r_q_y[s] | (DIV_QW'(w_gy) << (DIV_QW-1-s));
                r_den[s+1]   <= r_den[s];
                r_side[s+1]  <= r_side[s];
            end
        end
    end

    assign o_valid = r_valid[DIV_QW];
    assign o_quo_x = r_q_x[DIV_QW];
    assign o_quo_y = r_q_y[DIV_QW];
    assign o_side  = r_side[DIV_QW];

endmodule

`default_nettype wire

@@ rtl/core/velocity_motion_model_step_top.sv @@
// Velocity motion model step: moves one particle pose per beat along an arc,
// or a straight line when the angular velocity is zero. Depends on vmm_pkg and vmm_div.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------
//  in      | in        | i_in_valid / o_in_ready   | i_in_data  (t_in_item)
//  out     | out       | o_out_valid / i_out_ready | o_out_data (t_out_item)
//  cfg     | in        | i_cfg_valid / o_cfg_ready | i_cfg_data (sample period)
//
// One beat enters per cycle while the skid register is empty; the pipeline depth
// is set mostly by the CORDIC stages and the 54 quotient-bit divider stages.
// Reset is synchronous, active low; it clears valid bits and sets the sample
// period to 655. A result arriving behind a stalled output beat parks in a
// skid register; the pipeline holds only while the skid register is full.
`default_nettype none

module velocity_motion_model_step_top
    import vmm_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_item    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_item        o_out_data,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data
);

    localparam int CS = CORDIC_STAGES;

    logic        w_en;
    logic [15:0] r_dt;

    // configuration register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt <= 16'd655;
        end else if (i_cfg_valid) begin
            r_dt <= i_cfg_data;
        end
    end

    // ---------------- stage 0: noisy velocities ----------------
    logic               r0_valid;
    logic signed [31:0] r0_px, r0_py, r0_v, r0_w, r0_g;
    logic [15:0]        r0_th;
    logic               r0_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (w_en) begin
            r0_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_px   <= i_in_data.pos_x;
            r0_py   <= i_in_data.pos_y;
            r0_th   <= i_in_data.head_angle;
            r0_v    <= sat_to32(56'(i_in_data.lin_vel) + 56'(i_in_data.noise_lin));
            r0_w    <= sat_to32(56'(i_in_data.ang_vel) + 56'(i_in_data.noise_ang));
            r0_g    <= sat_to32(56'(i_in_data.turn_vel) + 56'(i_in_data.noise_turn));
            r0_last <= i_in_data.last_particle;
        end
    end

    // ---------------- stage 1: products with dt ----------------
    logic               r1_valid;
    logic signed [48:0] r1_pv, r1_pw, r1_pg;
    logic signed [31:0] r1_px, r1_py, r1_v, r1_w;
    logic [15:0]        r1_th;
    logic               r1_last;
    logic signed [16:0] w_dt_s;

    assign w_dt_s = $signed({1'b0, r_dt});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= r0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_pv   <= r0_v * w_dt_s;
            r1_pw   <= r0_w * w_dt_s;
            r1_pg   <= r0_g * w_dt_s;
            r1_px   <= r0_px;
            r1_py   <= r0_py;
            r1_v    <= r0_v;
            r1_w    <= r0_w;
            r1_th   <= r0_th;
            r1_last <= r0_last;
        end
    end

    // ---------------- stage 2: round to Q16.16 ----------------
    logic               r2_valid;
    logic signed [32:0] r2_wdt, r2_vd;
    logic signed [33:0] r2_tot;
    logic signed [31:0] r2_px, r2_py, r2_v, r2_w;
    logic [15:0]        r2_th;
    logic               r2_last;
    logic signed [32:0] w_wdt, w_gdt;

    assign w_wdt = 33'((r1_pw + 49'sd32768) >>> 16);
    assign w_gdt = 33'((r1_pg + 49'sd32768) >>> 16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_wdt  <= w_wdt;
            r2_tot  <= 34'(w_wdt) + 34'(w_gdt);
            r2_vd   <= 33'((r1_pv + 49'sd32768) >>> 16);
            r2_px   <= r1_px;
            r2_py   <= r1_py;
            r2_v    <= r1_v;
            r2_w    <= r1_w;
            r2_th   <= r1_th;
            r2_last <= r1_last;
        end
    end

    // ---------------- stage 3: radians to binary angle ----------------
    logic               r3_valid;
    logic [47:0]        r3_mw, r3_mt;
    logic signed [32:0] r3_vd;
    logic signed [31:0] r3_px, r3_py, r3_v, r3_w;
    logic [15:0]        r3_th;
    logic               r3_last;
    logic signed [63:0] w_mw, w_mt;
    logic signed [31:0] w_rad_s;

    assign w_rad_s = $signed({1'b0, RAD_TO_BAM});
    assign w_mw    = 64'(r2_wdt) * 64'(w_rad_s);
    assign w_mt    = 64'(r2_tot) * 64'(w_rad_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_mw   <= w_mw[47:0];
            r3_mt   <= w_mt[47:0];
            r3_vd   <= r2_vd;
            r3_px   <= r2_px;
            r3_py   <= r2_py;
            r3_v    <= r2_v;
            r3_w    <= r2_w;
            r3_th   <= r2_th;
            r3_last <= r2_last;
        end
    end

    // ---------------- stage 4: angles and new heading ----------------
    logic        r4_valid;
    logic [31:0] r4_th0, r4_th1;
    t_cside      r4_side;
    logic [47:0] w_bw, w_bt;
    logic [31:0] w_th32, w_head32;

    assign w_bw     = r3_mw + 48'd32768;
    assign w_bt     = r3_mt + 48'd32768;
    assign w_th32   = {r3_th, 16'h0000};
    assign w_head32 = w_th32 + w_bt[47:16] + 32'h0000_8000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (w_en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_th0       <= w_th32;
            r4_th1       <= w_th32 + w_bw[47:16];
            r4_side.px   <= r3_px;
            r4_side.py   <= r3_py;
            r4_side.v    <= r3_v;
            r4_side.w    <= r3_w;
            r4_side.vd   <= r3_vd;
            r4_side.head <= w_head32[31:16];
            r4_side.last <= r3_last;
        end
    end

    // ---------------- CORDIC: two lanes, one iteration per stage ----------------
    logic               r_cvalid [CS+1];
    t_cside             r_cside  [CS+1];
    logic signed [33:0] r_cx     [2][CS+1];
    logic signed [33:0] r_cy     [2][CS+1];
    logic signed [32:0] r_cz     [2][CS+1];
    logic               r_cflip  [2][CS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= CS; k++) begin
                r_cvalid[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_cvalid[0] <= r4_valid;
            for (int k = 0; k < CS; k++) begin
                r_cvalid[k+1] <= r_cvalid[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cside[0] <= r4_side;
            for (int k = 0; k < CS; k++) begin
                r_cside[k+1] <= r_cside[k];
            end
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic signed [32:0] w_z;

        assign w_z = 33'($signed((l == 0) ? r4_th0 : r4_th1));

        // fold the angle into the right half plane
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_cx[l][0] <= $signed(CORDIC_GAIN);
                r_cy[l][0] <= '0;
                priority if (w_z > QUARTER_TURN) begin
                    r_cz[l][0]    <= w_z - HALF_TURN;
                    r_cflip[l][0] <= 1'b1;
                end else if (w_z < -QUARTER_TURN) begin
                    r_cz[l][0]    <= w_z + HALF_TURN;
                    r_cflip[l][0] <= 1'b1;
                end else begin
                    r_cz[l][0]    <= w_z;
                    r_cflip[l][0] <= 1'b0;
                end
            end
        end

        for (genvar k = 0; k < CS; k++) begin : g_iter
            logic signed [33:0] w_dx, w_dy;
            logic signed [32:0] w_at;

            assign w_dx = r_cy[l][k] >>> k;
            assign w_dy = r_cx[l][k] >>> k;
            assign w_at = $signed({1'b0, ATAN_BAM[k]});

            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_cflip[l][k+1] <= r_cflip[l][k];
                    if (!r_cz[l][k][32]) begin
                        r_cx[l][k+1] <= r_cx[l][k] - w_dx;
                        r_cy[l][k+1] <= r_cy[l][k] + w_dy;
                        r_cz[l][k+1] <= r_cz[l][k] - w_at;
                    end else begin
                        r_cx[l][k+1] <= r_cx[l][k] + w_dx;
                        r_cy[l][k+1] <= r_cy[l][k] - w_dy;
                        r_cz[l][k+1] <= r_cz[l][k] + w_at;
                    end
                end
            end
        end
    end

    // ---------------- post stage: unfold and differences ----------------
    logic               rp_valid;
    logic signed [34:0] rp_c0, rp_s0;
    logic signed [35:0] rp_dsx, rp_dcy;
    t_cside             rp_side;
    logic signed [34:0] w_c0, w_s0, w_c1, w_s1;

    assign w_c0 = r_cflip[0][CS] ? -35'(r_cx[0][CS]) : 35'(r_cx[0][CS]);
    assign w_s0 = r_cflip[0][CS] ? -35'(r_cy[0][CS]) : 35'(r_cy[0][CS]);
    assign w_c1 = r_cflip[1][CS] ? -35'(r_cx[1][CS]) : 35'(r_cx[1][CS]);
    assign w_s1 = r_cflip[1][CS] ? -35'(r_cy[1][CS]) : 35'(r_cy[1][CS]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rp_valid <= 1'b0;
        end else if (w_en) begin
            rp_valid <= r_cvalid[CS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rp_c0   <= w_c0;
            rp_s0   <= w_s0;
            rp_dsx  <= 36'(w_s1) - 36'(w_s0);
            rp_dcy  <= 36'(w_c0) - 36'(w_c1);
            rp_side <= r_cside[CS];
        end
    end

    // ---------------- multiply stage ----------------
    logic               rm_valid;
    logic signed [67:0] rm_nx, rm_ny, rm_sx, rm_sy;
    t_cside             rm_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rm_valid <= 1'b0;
        end else if (w_en) begin
            rm_valid <= rp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rm_nx   <= 68'(rp_side.v) * 68'(rp_dsx);
            rm_ny   <= 68'(rp_side.v) * 68'(rp_dcy);
            rm_sx   <= 68'(rp_side.vd) * 68'(rp_c0);
            rm_sy   <= 68'(rp_side.vd) * 68'(rp_s0);
            rm_side <= rp_side;
        end
    end

    // ---------------- divider prep: magnitudes and straight-line result ----------------
    logic signed [37:0]  w_tx, w_ty;
    logic [31:0]         w_wabs;
    logic [DIV_DW-1:0]   w_den;
    logic [DIV_NW-1:0]   w_ax, w_ay, w_numx, w_numy;
    t_dside              w_dside;
    logic                w_dvalid;
    logic [DIV_QW-1:0]   w_qx, w_qy;
    t_dside              w_dout;

    assign w_tx   = 38'((rm_sx + 68'sd536870912) >>> 30);
    assign w_ty   = 38'((rm_sy + 68'sd536870912) >>> 30);
    assign w_wabs = rm_side.w[31] ? 32'(-33'(rm_side.w)) : rm_side.w;
    assign w_den  = DIV_DW'(w_wabs) << 14;
    assign w_ax   = rm_nx[67] ? DIV_NW'(-rm_nx) : DIV_NW'(rm_nx);
    assign w_ay   = rm_ny[67] ? DIV_NW'(-rm_ny) : DIV_NW'(rm_ny);
    assign w_numx = w_ax + DIV_NW'(w_den >> 1);
    assign w_numy = w_ay + DIV_NW'(w_den >> 1);

    always_comb begin
        w_dside.px   = rm_side.px;
        w_dside.py   = rm_side.py;
        w_dside.nx0  = sat_to32(56'(rm_side.px) + 56'(w_tx));
        w_dside.ny0  = sat_to32(56'(rm_side.py) + 56'(w_ty));
        w_dside.wz   = (rm_side.w == 32'sd0);
        w_dside.negx = rm_nx[67] ^ rm_side.w[31];
        w_dside.negy = rm_ny[67] ^ rm_side.w[31];
        w_dside.head = rm_side.head;
        w_dside.last = rm_side.last;
    end

    vmm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (rm_valid),
        .i_num_x (w_numx),
        .i_num_y (w_numy),
        .i_den   (w_den),
        .i_side  (w_dside),
        .o_valid (w_dvalid),
        .o_quo_x (w_qx),
        .o_quo_y (w_qy),
        .o_side  (w_dout)
    );

    // ---------------- final sum, select and saturate ----------------
    logic signed [DIV_QW:0] w_sqx, w_sqy;
    t_out_item              w_res;

    assign w_sqx = w_dout.negx ? -$signed({1'b0, w_qx}) : $signed({1'b0, w_qx});
    assign w_sqy = w_dout.negy ? -$signed({1'b0, w_qy}) : $signed({1'b0, w_qy});

    always_comb begin
        w_res.next_x       = w_dout.wz ? w_dout.nx0
                                       : sat_to32(56'(w_dout.px) + 56'(w_sqx));
        w_res.next_y       = w_dout.wz ? w_dout.ny0
                                       : sat_to32(56'(w_dout.py) + 56'(w_sqy));
        w_res.next_heading = w_dout.head;
        w_res.batch_end    = w_dout.last;
    end

    // ---------------- output register with skid ----------------
    logic      r_ov, r_sv;
    t_out_item r_o, r_s;

    assign w_en        = ~r_sv;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (i_out_ready || !r_ov) begin
            if (r_sv) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end else begin
                r_ov <= w_dvalid;
            end
        end else if (w_dvalid && w_en) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_out_ready || !r_ov) begin
            r_o <= r_sv ? r_s : w_res;
        end else if (w_dvalid && w_en) begin
            r_s <= w_res;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/vmm_checker.sv @@
// Port-level checks for the velocity motion model top, bound to every instance.
// Depends on vmm_pkg and the assertion macro header.
`default_nettype none
`include "velocity_motion_model_step_top_defines.svh"

module vmm_checker
    import vmm_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_in_ready,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_data
);

    // hold a stalled output beat
    `VMM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "out beat dropped while stalled")
    `VMM_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_out_data), "out beat changed while stalled")
    // back-pressure only when a result is waiting
    `VMM_ASSERT_NOW(a_ready_cause, i_clk, i_rst_n, !o_in_ready, o_out_valid && !$past(i_out_ready), "input held off without a waiting result")
    // drop all results on reset
    `VMM_ASSERT_RST(a_rst_empty, i_clk, !i_rst_n, !o_out_valid, "result shown right after reset")

endmodule

bind velocity_motion_model_step_top vmm_checker u_vmm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
